@@ rtl/core/ssp_pkg.sv @@
// Package: shared types, register indexes and constants of the sensor serial port master.
`default_nettype none
package ssp_pkg;

	localparam int TickW  = 8;
	localparam int AddrW  = 7;
	localparam int ByteW  = 8;
	localparam int ShiftW = 16;
	localparam int CountW = 5;
	localparam int CfgIdxW = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_SEND_LOW  = 3'd1,
		PH_SEND_HIGH = 3'd2,
		PH_TURN      = 3'd3,
		PH_RECV_LOW  = 3'd4,
		PH_RECV_HIGH = 3'd5
	} phase_t;

	localparam logic [CfgIdxW-1:0] REG_CLOCK_LOW  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CLOCK_HIGH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TURNAROUND = 2'd2;

	localparam logic [TickW-1:0] CLOCK_LOW_RESET  = 8'd1;
	localparam logic [TickW-1:0] CLOCK_HIGH_RESET = 8'd1;
	localparam logic [TickW-1:0] TURNAROUND_RESET = 8'd3;

	localparam logic WRITE_FLAG = 1'b1;
	localparam logic [CountW-1:0] WRITE_BITS = 5'd16;
	localparam logic [CountW-1:0] BYTE_BITS  = 5'd8;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [AddrW-1:0] address;
		logic [ByteW-1:0] write_data;
		logic             data_pin_in;
	} item_t;

	typedef struct packed {
		logic             clock_pin;
		logic             data_pin_out;
		logic             data_pin_drive;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] read_data;
		logic             rejected;
	} result_t;

	typedef struct packed {
		logic [TickW-1:0] clock_low_ticks;
		logic [TickW-1:0] clock_high_ticks;
		logic [TickW-1:0] turnaround_ticks;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/ssp_cmd_if.sv @@
// Interface: request channel carrying one tick item per beat.
`default_nettype none
interface ssp_cmd_if;
	logic           valid;
	logic           ready;
	ssp_pkg::item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ssp_rsp_if.sv @@
// Interface: result channel carrying the pin levels and status of one tick per beat.
`default_nettype none
interface ssp_rsp_if;
	logic             valid;
	logic             ready;
	ssp_pkg::result_t res;

	modport source (output valid, output res, input ready);
	modport sink   (input valid, input res, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ssp_cfg_if.sv @@
// Interface: configuration write channel with register index and data.
`default_nettype none
interface ssp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ssp_pkg::CfgIdxW-1:0]   index;
	logic [ssp_pkg::TickW-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sensor_serial_port_master.sv @@
// Top level: two-wire sensor serial port master with input and result stages.
//
//   channel  dir  beat                                    notes
//   cmd      in   opcode, address, write_data, data_pin_in  one protocol tick per beat
//   rsp      out  pin levels, busy, done, read_data, rejected one beat per cmd beat
//   cfg      in   index, data                             always ready
//
// Each tick goes through a registered input stage and result stage; one tick is accepted
// every cycle unless the result side stalls. The sequencer state advances as the tick
// leaves the input stage. Reset returns the sequencer to idle and the timing registers to
// 1, 1 and 3. A stalled result holds in the result stage while one more tick waits in
// the input stage.
`default_nettype none
module sensor_serial_port_master (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssp_cmd_if.sink    cmd,
	ssp_rsp_if.source  rsp,
	ssp_cfg_if.sink    cfg
);

	ssp_pkg::item_t   item_s1;
	logic             vld_s1;
	ssp_pkg::result_t res_s2, res_n;
	logic             vld_s2;
	logic             adv_s1, step;
	ssp_pkg::cfg_t    cfg_val;

	assign adv_s1    = !vld_s2 || rsp.ready;
	assign step      = vld_s1 && adv_s1;
	assign cmd.ready = !vld_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	ssp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	ssp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_val),
		.res    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) item_s1 <= cmd.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_s2 <= res_n;
	end

	assign rsp.valid = vld_s2;
	assign rsp.res   = res_s2;

	// done ends the transaction on that very tick
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.done_res) |-> !res_s2.busy_res)
		else $error("done reported while still busy");

	// the data line is only driven inside a transaction
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (res_s2.data_pin_drive || !res_s2.clock_pin)) |-> res_s2.busy_res)
		else $error("pins active while idle");

	// read data appears only with done
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (res_s2.read_data != '0)) |-> res_s2.done_res)
		else $error("read data outside done tick");

	// a stalled result stage keeps the input stage from advancing the sequencer
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rsp.ready) |-> !step)
		else $error("sequencer stepped during result stall");

endmodule
`default_nettype wire

@@ rtl/core/ssp_cfg_regs.sv @@
// Module: timing configuration registers of the serial port master.
`default_nettype none
module ssp_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [ssp_pkg::CfgIdxW-1:0] wr_index,
	input  wire logic [ssp_pkg::TickW-1:0]   wr_data,
	output ssp_pkg::cfg_t                    cfg
);

	ssp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_low_ticks  <= ssp_pkg::CLOCK_LOW_RESET;
			cfg_q.clock_high_ticks <= ssp_pkg::CLOCK_HIGH_RESET;
			cfg_q.turnaround_ticks <= ssp_pkg::TURNAROUND_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ssp_pkg::REG_CLOCK_LOW:  cfg_q.clock_low_ticks  <= wr_data;
				ssp_pkg::REG_CLOCK_HIGH: cfg_q.clock_high_ticks <= wr_data;
				ssp_pkg::REG_TURNAROUND: cfg_q.turnaround_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/ssp_engine.sv @@
// Module: protocol sequencer; state registers and the per-tick next-state and pin logic.
`default_nettype none
module ssp_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire ssp_pkg::item_t  item,
	input  wire ssp_pkg::cfg_t   cfg,
	output ssp_pkg::result_t     res
);

	ssp_pkg::phase_t                phase_q, phase_n;
	logic [ssp_pkg::CountW-1:0]     bit_count_q, bit_count_n, bit_count_dec;
	logic [ssp_pkg::ShiftW-1:0]     send_q, send_n;
	logic [ssp_pkg::ByteW-1:0]      recv_q, recv_n;
	logic [ssp_pkg::TickW-1:0]      timer_q, timer_n, limit, limit_eff;
	logic                           is_read_q, is_read_n;
	logic                           request, over, done, rejected, clk_low, drive;
	logic [ssp_pkg::ByteW-1:0]      rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ssp_pkg::PH_IDLE;
			bit_count_q <= '0;
			send_q      <= '0;
			recv_q      <= '0;
			timer_q     <= '0;
			is_read_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			bit_count_q <= bit_count_n;
			send_q      <= send_n;
			recv_q      <= recv_n;
			timer_q     <= timer_n;
			is_read_q   <= is_read_n;
		end
	end

	// length of the current timed phase; a zero register counts as one tick
	always_comb begin
		case (phase_q)
			ssp_pkg::PH_SEND_LOW, ssp_pkg::PH_RECV_LOW:   limit = cfg.clock_low_ticks;
			ssp_pkg::PH_SEND_HIGH, ssp_pkg::PH_RECV_HIGH: limit = cfg.clock_high_ticks;
			ssp_pkg::PH_TURN:                             limit = cfg.turnaround_ticks;
			default:                                      limit = 8'd1;
		endcase
		limit_eff = (limit == '0) ? 8'd1 : limit;
		over      = (timer_q >= limit_eff);
	end

	assign request       = item.opcode inside {ssp_pkg::OP_WRITE, ssp_pkg::OP_READ};
	assign bit_count_dec = bit_count_q - 5'd1;

	always_comb begin
		phase_n     = phase_q;
		bit_count_n = bit_count_q;
		send_n      = send_q;
		recv_n      = recv_q;
		is_read_n   = is_read_q;
		timer_n     = over ? timer_q : timer_q + 8'd1;
		done        = 1'b0;
		rejected    = 1'b0;
		rd          = '0;
		case (phase_q)
			ssp_pkg::PH_IDLE: begin
				timer_n = timer_q;
				if (request) begin
					is_read_n = (item.opcode == ssp_pkg::OP_READ);
					recv_n    = '0;
					if (is_read_n) begin
						send_n      = {1'b0, item.address, 8'h00};
						bit_count_n = ssp_pkg::BYTE_BITS;
					end else begin
						send_n      = {ssp_pkg::WRITE_FLAG, item.address, item.write_data};
						bit_count_n = ssp_pkg::WRITE_BITS;
					end
					phase_n = ssp_pkg::PH_SEND_LOW;
					timer_n = 8'd1;
				end
			end
			ssp_pkg::PH_SEND_LOW: begin
				rejected = request;
				if (over) begin
					phase_n = ssp_pkg::PH_SEND_HIGH;
					timer_n = 8'd1;
				end
			end
			ssp_pkg::PH_SEND_HIGH: begin
				rejected = request;
				if (over) begin
					send_n      = {send_q[ssp_pkg::ShiftW-2:0], 1'b0};
					bit_count_n = bit_count_dec;
					if (bit_count_dec != '0) begin
						phase_n = ssp_pkg::PH_SEND_LOW;
						timer_n = 8'd1;
					end else if (is_read_q) begin
						phase_n = ssp_pkg::PH_TURN;
						timer_n = 8'd1;
					end else begin
						phase_n = ssp_pkg::PH_IDLE;
						timer_n = '0;
						done    = 1'b1;
					end
				end
			end
			ssp_pkg::PH_TURN: begin
				rejected = request;
				if (over) begin
					bit_count_n = ssp_pkg::BYTE_BITS;
					phase_n     = ssp_pkg::PH_RECV_LOW;
					timer_n     = 8'd1;
				end
			end
			ssp_pkg::PH_RECV_LOW: begin
				rejected = request;
				if (over) begin
					phase_n = ssp_pkg::PH_RECV_HIGH;
					timer_n = 8'd1;
				end
			end
			ssp_pkg::PH_RECV_HIGH: begin
				rejected = request;
				// sample on the first tick after the rising edge
				if (timer_q == 8'd1) recv_n = {recv_q[ssp_pkg::ByteW-2:0], item.data_pin_in};
				if (over) begin
					bit_count_n = bit_count_dec;
					if (bit_count_dec != '0) begin
						phase_n = ssp_pkg::PH_RECV_LOW;
						timer_n = 8'd1;
					end else begin
						phase_n = ssp_pkg::PH_IDLE;
						timer_n = '0;
						done    = 1'b1;
						rd      = recv_n;
					end
				end
			end
			default: begin
				phase_n = ssp_pkg::PH_IDLE;
				timer_n = '0;
			end
		endcase
	end

	assign clk_low = (phase_n == ssp_pkg::PH_SEND_LOW) || (phase_n == ssp_pkg::PH_RECV_LOW);
	assign drive   = (phase_n == ssp_pkg::PH_SEND_LOW) || (phase_n == ssp_pkg::PH_SEND_HIGH);

	always_comb begin
		res.clock_pin      = !clk_low;
		res.data_pin_out   = drive & send_n[ssp_pkg::ShiftW-1];
		res.data_pin_drive = drive;
		res.busy_res       = (phase_n != ssp_pkg::PH_IDLE);
		res.done_res       = done;
		res.read_data      = rd;
		res.rejected       = rejected;
	end

endmodule
`default_nettype wire

@@ test/ssp_tick_checker.sv @@
// Checker: predicts the pin levels and status of every tick and compares them with the result beats.
`timescale 1ns / 100ps
module ssp_tick_checker
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ssp_cmd_if          cmd,
	ssp_rsp_if          rsp,
	ssp_cfg_if          cfg,
	output int unsigned outstanding,
	output int unsigned mismatches
);

	logic [TickW-1:0]  low_ticks;
	logic [TickW-1:0]  high_ticks;
	logic [TickW-1:0]  turn_ticks;

	phase_t            seq_phase;
	logic [CountW-1:0] bits_left;
	logic [ShiftW-1:0] tx_shift;
	logic [ByteW-1:0]  rx_shift;
	logic [TickW-1:0]  ticks_spent;
	logic              reading;

	result_t           pin_levels_due[$];
	result_t           want;
	int unsigned       mismatch_cnt = 0;

	function automatic logic [TickW-1:0] at_least_one(logic [TickW-1:0] v);
		return (v == '0) ? TickW'(1) : v;
	endfunction

	// Count one more tick of the current phase; true once the phase has used up its length.
	function automatic bit phase_spent(logic [TickW-1:0] len);
		if (ticks_spent < at_least_one(len)) begin
			ticks_spent = ticks_spent + 1'b1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void enter_phase(phase_t p);
		seq_phase   = p;
		ticks_spent = TickW'(1);
	endfunction

	function automatic void finish_transfer();
		seq_phase   = PH_IDLE;
		ticks_spent = '0;
	endfunction

	function automatic result_t advance_sequencer(item_t it);
		result_t          r;
		logic             req;
		logic             rej;
		logic             done;
		logic [ByteW-1:0] rd;
		logic             clk_low;
		logic             drive;
		req  = (it.opcode == OP_WRITE) || (it.opcode == OP_READ);
		rej  = 1'b0;
		done = 1'b0;
		rd   = '0;
		case (seq_phase)
			PH_IDLE: begin
				if (req) begin
					reading  = (it.opcode == OP_READ);
					rx_shift = '0;
					if (reading) begin
						tx_shift  = {1'b0, it.address, {ByteW{1'b0}}};
						bits_left = BYTE_BITS;
					end else begin
						tx_shift  = {WRITE_FLAG, it.address, it.write_data};
						bits_left = WRITE_BITS;
					end
					enter_phase(PH_SEND_LOW);
				end
			end
			PH_SEND_LOW: begin
				rej = req;
				if (phase_spent(low_ticks))
					enter_phase(PH_SEND_HIGH);
			end
			PH_SEND_HIGH: begin
				rej = req;
				if (phase_spent(high_ticks)) begin
					tx_shift  = tx_shift << 1;
					bits_left = bits_left - 1'b1;
					if (bits_left != '0) begin
						enter_phase(PH_SEND_LOW);
					end else if (reading) begin
						enter_phase(PH_TURN);
					end else begin
						finish_transfer();
						done = 1'b1;
					end
				end
			end
			PH_TURN: begin
				rej = req;
				if (phase_spent(turn_ticks)) begin
					bits_left = BYTE_BITS;
					enter_phase(PH_RECV_LOW);
				end
			end
			PH_RECV_LOW: begin
				rej = req;
				if (phase_spent(low_ticks))
					enter_phase(PH_RECV_HIGH);
			end
			PH_RECV_HIGH: begin
				rej = req;
				// sample on the first tick after the rising edge
				if (ticks_spent == TickW'(1))
					rx_shift = {rx_shift[ByteW-2:0], it.data_pin_in};
				if (phase_spent(high_ticks)) begin
					bits_left = bits_left - 1'b1;
					if (bits_left != '0) begin
						enter_phase(PH_RECV_LOW);
					end else begin
						finish_transfer();
						done = 1'b1;
						rd   = rx_shift;
					end
				end
			end
			default: begin
				finish_transfer();
			end
		endcase
		clk_low = (seq_phase == PH_SEND_LOW) || (seq_phase == PH_RECV_LOW);
		drive   = (seq_phase == PH_SEND_LOW) || (seq_phase == PH_SEND_HIGH);
		r.clock_pin      = !clk_low;
		r.data_pin_out   = drive ? tx_shift[ShiftW-1] : 1'b0;
		r.data_pin_drive = drive;
		r.busy_res       = (seq_phase != PH_IDLE);
		r.done_res       = done;
		r.read_data      = rd;
		r.rejected       = rej;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			mismatch_cnt++;
			$display("%0t %s: expected %0h actual %0h", $time, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ticks   = CLOCK_LOW_RESET;
			high_ticks  = CLOCK_HIGH_RESET;
			turn_ticks  = TURNAROUND_RESET;
			seq_phase   = PH_IDLE;
			bits_left   = '0;
			tx_shift    = '0;
			rx_shift    = '0;
			ticks_spent = '0;
			reading     = 1'b0;
			pin_levels_due.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pin_levels_due.size() == 0) begin
					mismatch_cnt++;
					$display("%0t result beat: expected none actual %0h", $time, rsp.res);
				end else begin
					want = pin_levels_due.pop_front();
					check_field("clock_pin", want.clock_pin, rsp.res.clock_pin);
					check_field("data_pin_out", want.data_pin_out, rsp.res.data_pin_out);
					check_field("data_pin_drive", want.data_pin_drive, rsp.res.data_pin_drive);
					check_field("busy_res", want.busy_res, rsp.res.busy_res);
					check_field("done_res", want.done_res, rsp.res.done_res);
					check_field("read_data", want.read_data, rsp.res.read_data);
					check_field("rejected", want.rejected, rsp.res.rejected);
				end
			end
			if (cmd.valid && cmd.ready)
				pin_levels_due.push_back(advance_sequencer(cmd.item));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_CLOCK_LOW:  low_ticks  = cfg.data;
					REG_CLOCK_HIGH: high_ticks = cfg.data;
					REG_TURNAROUND: turn_ticks = cfg.data;
					default: ;
				endcase
			end
			outstanding <= pin_levels_due.size();
			mismatches  <= mismatch_cnt;
		end
	end

endmodule

@@ test/sensor_serial_port_master_tb.sv @@
// Testbench top: drives ticks and timing writes into the sensor serial port master and gives the verdict.
`timescale 1ns / 100ps
module sensor_serial_port_master_tb;
	import ssp_pkg::*;

	localparam int unsigned   QuietLimit = 400;
	localparam logic [1:0]    OpUnused   = 2'd3;
	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        gaps_on = 1'b1;
	logic [3:0]  ready_hold;
	int unsigned quiet_cycles;
	int unsigned outstanding;
	int unsigned mismatches;
	wire         any_beat;

	always #6 clk = ~clk;

	ssp_cmd_if cmd();
	ssp_rsp_if rsp();
	ssp_cfg_if cfg();

	sensor_serial_port_master uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	ssp_tick_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.cfg         (cfg),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	assign any_beat = (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
	                  (cfg.valid && cfg.ready);

	// result side: drop ready at random while gaps are on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			ready_hold <= '0;
		end else if (ready_hold != '0) begin
			ready_hold <= ready_hold - 1'b1;
		end else if (gaps_on && $urandom_range(0, 11) == 0) begin
			rsp.ready  <= 1'b0;
			ready_hold <= 4'($urandom_range(0, 11));
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if (any_beat) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QuietLimit) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_tick(logic [1:0] op, logic [AddrW-1:0] addr, logic [ByteW-1:0] wd);
		item_t it;
		if (gaps_on && $urandom_range(0, 15) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		it.opcode      = op;
		it.address     = addr;
		it.write_data  = wd;
		it.data_pin_in = 1'($urandom_range(0, 1));
		cmd.item  <= it;
		cmd.valid <= 1'b1;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	task automatic plain_ticks(int unsigned n);
		repeat (n) send_tick(OP_TICK, AddrW'($urandom), ByteW'($urandom));
	endtask

	// Mostly plain ticks, with requests sprinkled in; those landing mid-transfer get rejected.
	task automatic mixed_ticks(int unsigned n, int unsigned req_pct);
		int unsigned r;
		logic [1:0]  op;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < req_pct)
				op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
			else if (r < req_pct + 2)
				op = OpUnused;
			else
				op = OP_TICK;
			send_tick(op, AddrW'($urandom), ByteW'($urandom));
		end
	endtask

	// Hold off the sender until every result beat is back.
	task automatic settle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
		cfg.index <= idx;
		cfg.data  <= val;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic set_timing(logic [TickW-1:0] lo, logic [TickW-1:0] hi, logic [TickW-1:0] turn);
		write_reg(REG_CLOCK_LOW, lo);
		write_reg(REG_CLOCK_HIGH, hi);
		write_reg(REG_TURNAROUND, turn);
		if ($urandom_range(0, 2) == 0)
			write_reg(RegUnused, TickW'($urandom));
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [TickW-1:0] pick_ticks();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 85)
			return TickW'($urandom_range(1, 4));
		return TickW'($urandom_range(5, 12));
	endfunction

	initial begin
		int unsigned k;
		cmd.valid <= 1'b0;
		cmd.item  <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data  <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: a write takes 33 ticks, the last one completing it
		send_tick(OpUnused, 7'h55, 8'hAA);
		send_tick(OP_WRITE, 7'h7F, 8'hFF);
		plain_ticks(10);
		send_tick(OP_READ, 7'h00, 8'h00);
		plain_ticks(20);
		send_tick(OP_WRITE, 7'h2A, 8'h00);
		send_tick(OP_READ, 7'h7F, 8'h00);
		plain_ticks(36);
		send_tick(OP_WRITE, 7'h00, 8'h00);
		plain_ticks(34);

		// zero in every register counts as one tick
		settle();
		set_timing('0, '0, '0);
		send_tick(OP_READ, 7'h3C, 8'hC3);
		plain_ticks(40);

		// longest phases, then cut them short mid-transfer
		settle();
		set_timing(8'd255, 8'd255, 8'd255);
		send_tick(OP_WRITE, AddrW'($urandom), ByteW'($urandom));
		mixed_ticks(300, 1);
		settle();
		set_timing(8'd2, 8'd1, 8'd2);
		mixed_ticks(120, 3);

		settle();
		set_timing(8'd1, 8'd1, 8'd255);
		send_tick(OP_READ, AddrW'($urandom), ByteW'($urandom));
		mixed_ticks(320, 1);

		for (k = 0; k < 8; k++) begin
			settle();
			set_timing(pick_ticks(), pick_ticks(), pick_ticks());
			if (k == 7)
				gaps_on <= 1'b0;
			mixed_ticks((k == 7) ? 200 : 130, $urandom_range(2, 12));
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ssp_pkg.sv
rtl/core/ssp_cmd_if.sv
rtl/core/ssp_rsp_if.sv
rtl/core/ssp_cfg_if.sv
rtl/core/ssp_cfg_regs.sv
rtl/core/ssp_engine.sv
rtl/core/sensor_serial_port_master.sv
test/ssp_tick_checker.sv
test/sensor_serial_port_master_tb.sv
